[src/rpy_pkg.sv]
// shared constants, types and helpers of the pose to transform unit
package rpy_pkg;

   // default field widths
   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int COEF_WIDTH_DEF  = 16;
   localparam int POS_WIDTH_DEF   = 24;

   // internal fixed point widths: Q30 sin/cos, angle accumulator, Q60 products
   localparam int QW    = 33;
   localparam int ZW    = 34;
   localparam int PRW   = 66;
   localparam int STEPS = 30;

   // lane order of the three angles
   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_YAW   = 2;
   localparam int LANES      = 3;

   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [QW-1:0] GAIN_Q30    = 33'sd652032874;

   // sine and cosine of one angle in Q30
   typedef struct packed {
      logic signed [QW-1:0] s;
      logic signed [QW-1:0] c;
   } sc_type;

   // truncated Q30 arctangent of 2^-idx
   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:  v = 34'sd843314856;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043836;
         5'd3:  v = 34'sd133525158;
         5'd4:  v = 34'sd67021686;
         5'd5:  v = 34'sd33543515;
         5'd6:  v = 34'sd16775850;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194282;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048575;
         5'd11: v = 34'sd524287;
         5'd12: v = 34'sd262143;
         5'd13: v = 34'sd131071;
         5'd14: v = 34'sd65535;
         5'd15: v = 34'sd32767;
         5'd16: v = 34'sd16383;
         5'd17: v = 34'sd8191;
         5'd18: v = 34'sd4095;
         5'd19: v = 34'sd2047;
         5'd20: v = 34'sd1023;
         5'd21: v = 34'sd511;
         5'd22: v = 34'sd255;
         5'd23: v = 34'sd127;
         5'd24: v = 34'sd63;
         5'd25: v = 34'sd31;
         5'd26: v = 34'sd15;
         5'd27: v = 34'sd7;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // full signed product of two Q30 values
   function automatic logic signed [PRW-1:0] smul(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
      return PRW'(a) * PRW'(b);
   endfunction

   // Q60 back to Q30, round half up
   function automatic logic signed [QW-1:0] round30(input logic signed [PRW-1:0] p);
      logic signed [PRW-1:0] r;
      r = (p + (PRW'(1) <<< 29)) >>> 30;
      return r[QW-1:0];
   endfunction

endpackage

[src/rpy_if.sv]
// request and response stream interfaces
interface rpy_req_if #(
   parameter int POS_WIDTH   = 24,
   parameter int ANGLE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [POS_WIDTH-1:0]   pos_x;
   logic signed [POS_WIDTH-1:0]   pos_y;
   logic signed [POS_WIDTH-1:0]   pos_z;
   logic signed [ANGLE_WIDTH-1:0] roll_angle;
   logic signed [ANGLE_WIDTH-1:0] pitch_angle;
   logic signed [ANGLE_WIDTH-1:0] yaw_angle;

   modport source (output valid, pos_x, pos_y, pos_z, roll_angle, pitch_angle,
                   yaw_angle, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, roll_angle, pitch_angle,
                 yaw_angle, output ready);
endinterface

interface rpy_rsp_if #(
   parameter int POS_WIDTH  = 24,
   parameter int COEF_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] rot_00;
   logic signed [COEF_WIDTH-1:0] rot_01;
   logic signed [COEF_WIDTH-1:0] rot_02;
   logic signed [COEF_WIDTH-1:0] rot_10;
   logic signed [COEF_WIDTH-1:0] rot_11;
   logic signed [COEF_WIDTH-1:0] rot_12;
   logic signed [COEF_WIDTH-1:0] rot_20;
   logic signed [COEF_WIDTH-1:0] rot_21;
   logic signed [COEF_WIDTH-1:0] rot_22;
   logic signed [POS_WIDTH-1:0]  trans_x;
   logic signed [POS_WIDTH-1:0]  trans_y;
   logic signed [POS_WIDTH-1:0]  trans_z;

   modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                   rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, input ready);
   modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                 rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, output ready);
endinterface

[src/rpy_sincos.sv]
// three-lane pipelined cordic: angle fold, one rotation per stage, sign fix
module rpy_sincos
   import rpy_pkg::*;
#(
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
   parameter int POS_WIDTH   = POS_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   output logic                          in_rdy,
   input  logic signed [ANGLE_WIDTH-1:0] angle [LANES],
   input  logic signed [POS_WIDTH-1:0]   pos_in [LANES],
   output logic                          out_vld,
   input  logic                          out_rdy,
   output sc_type                        sc_out [LANES],
   output logic signed [POS_WIDTH-1:0]   pos_out [LANES]
);

   localparam int SH   = 33 - ANGLE_WIDTH;
   localparam int NSTG = STEPS + 2;

   logic                        vld_ff [NSTG];
   logic                        en     [NSTG];
   logic signed [QW-1:0]        x_ff   [STEPS+1][LANES];
   logic signed [QW-1:0]        y_ff   [STEPS+1][LANES];
   logic signed [ZW-1:0]        z_ff   [STEPS+1][LANES];
   logic                        neg_ff [STEPS+1][LANES];
   logic signed [POS_WIDTH-1:0] pos_ff [STEPS+1][LANES];
   sc_type                      sc_ff  [LANES];
   logic signed [POS_WIDTH-1:0] pout_ff [LANES];

   // stage advance chain: a stage loads when empty or when it drains
   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || out_rdy;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_rdy  = en[0];
   assign out_vld = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) vld_ff[0] <= in_vld;
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // angle to Q30 and fold into the half plane around zero
   for (genvar l = 0; l < LANES; l++) begin : g_fold
      logic signed [ZW-1:0] theta;
      logic signed [ZW-1:0] z_in;
      logic                 neg_in;

      always_comb begin
         theta  = {{(ZW-ANGLE_WIDTH){angle[l][ANGLE_WIDTH-1]}}, angle[l]} <<< SH;
         z_in   = theta;
         neg_in = 1'b0;
         if (theta > HALF_PI_Q30) begin
            z_in   = theta - PI_Q30;
            neg_in = 1'b1;
         end else if (theta < -HALF_PI_Q30) begin
            z_in   = theta + PI_Q30;
            neg_in = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[0]) begin
            x_ff[0][l]   <= GAIN_Q30;
            y_ff[0][l]   <= '0;
            z_ff[0][l]   <= z_in;
            neg_ff[0][l] <= neg_in;
            pos_ff[0][l] <= pos_in[l];
         end
      end
   end

   // one micro-rotation per stage
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic signed [QW-1:0] dx;
         logic signed [QW-1:0] dy;
         logic signed [ZW-1:0] at;

         assign dx = y_ff[k-1][l] >>> (k - 1);
         assign dy = x_ff[k-1][l] >>> (k - 1);
         assign at = atan_q30(5'(k - 1));

         always_ff @(posedge clock) begin
            if (en[k]) begin
               if (z_ff[k-1][l] >= 0) begin
                  x_ff[k][l] <= x_ff[k-1][l] - dx;
                  y_ff[k][l] <= y_ff[k-1][l] + dy;
                  z_ff[k][l] <= z_ff[k-1][l] - at;
               end else begin
                  x_ff[k][l] <= x_ff[k-1][l] + dx;
                  y_ff[k][l] <= y_ff[k-1][l] - dy;
                  z_ff[k][l] <= z_ff[k-1][l] + at;
               end
               neg_ff[k][l] <= neg_ff[k-1][l];
               pos_ff[k][l] <= pos_ff[k-1][l];
            end
         end
      end
   end

   // undo the fold by negating both results
   always_ff @(posedge clock) begin
      if (en[NSTG-1]) begin
         for (int l = 0; l < LANES; l++) begin
            sc_ff[l].c <= neg_ff[STEPS][l] ? -x_ff[STEPS][l] : x_ff[STEPS][l];
            sc_ff[l].s <= neg_ff[STEPS][l] ? -y_ff[STEPS][l] : y_ff[STEPS][l];
            pout_ff[l] <= pos_ff[STEPS][l];
         end
      end
   end

   assign sc_out  = sc_ff;
   assign pos_out = pout_ff;

endmodule

[src/rpy_matrix.sv]
// five-stage product, sum and rounding pipeline for the rotation entries
module rpy_matrix
   import rpy_pkg::*;
#(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_vld,
   output logic                         in_rdy,
   input  sc_type                       sc_in [LANES],
   input  logic signed [POS_WIDTH-1:0]  pos_in [LANES],
   output logic                         out_vld,
   input  logic                         out_rdy,
   output logic signed [COEF_WIDTH-1:0] rot [9],
   output logic signed [POS_WIDTH-1:0]  trans [LANES]
);

   localparam int NSTG = 5;
   localparam int FRAC = COEF_WIDTH - 2;
   localparam logic signed [PRW-1:0] RND = PRW'(1) <<< (59 - FRAC);
   localparam logic signed [PRW-1:0] LIM = PRW'(1) <<< FRAC;

   logic vld_ff [NSTG];
   logic en     [NSTG];

   // stage 1: direct products
   logic signed [PRW-1:0] cycp_ff, sycp_ff, cpsr_ff, cpcr_ff, cysp_p_ff, sysp_p_ff;
   logic signed [PRW-1:0] cycr1_ff, sysr1_ff, cysr1_ff, sycr1_ff;
   logic signed [QW-1:0]  sr1_ff, cr1_ff, sp1_ff;
   // stage 2: rounded Q30 pairs
   logic signed [QW-1:0]  cysp_ff, sysp_ff, sr2_ff, cr2_ff, sp2_ff;
   logic signed [PRW-1:0] cycp2_ff, sycp2_ff, cpsr2_ff, cpcr2_ff;
   logic signed [PRW-1:0] cycr2_ff, sysr2_ff, cysr2_ff, sycr2_ff;
   // stage 3: three-factor products
   logic signed [PRW-1:0] qa_ff, qb_ff, qc_ff, qd_ff;
   logic signed [PRW-1:0] cycp3_ff, sycp3_ff, cpsr3_ff, cpcr3_ff;
   logic signed [PRW-1:0] cycr3_ff, sysr3_ff, cysr3_ff, sycr3_ff;
   logic signed [QW-1:0]  sp3_ff;
   // stage 4: Q60 entries; stage 5: output
   logic signed [PRW-1:0]        ent_ff [9];
   logic signed [COEF_WIDTH-1:0] rot_ff [9];
   logic signed [POS_WIDTH-1:0]  pos_ff [NSTG][LANES];
   logic signed [PRW-1:0]        rnd    [9];

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || out_rdy;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_rdy  = en[0];
   assign out_vld = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) vld_ff[0] <= in_vld;
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // position rides along
   always_ff @(posedge clock) begin
      if (en[0]) pos_ff[0] <= pos_in;
      for (int k = 1; k < NSTG; k++) begin
         if (en[k]) pos_ff[k] <= pos_ff[k-1];
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (en[0]) begin
         cycp_ff   <= smul(sc_in[LANE_YAW].c, sc_in[LANE_PITCH].c);
         sycp_ff   <= smul(sc_in[LANE_YAW].s, sc_in[LANE_PITCH].c);
         cpsr_ff   <= smul(sc_in[LANE_PITCH].c, sc_in[LANE_ROLL].s);
         cpcr_ff   <= smul(sc_in[LANE_PITCH].c, sc_in[LANE_ROLL].c);
         cysp_p_ff <= smul(sc_in[LANE_YAW].c, sc_in[LANE_PITCH].s);
         sysp_p_ff <= smul(sc_in[LANE_YAW].s, sc_in[LANE_PITCH].s);
         cycr1_ff  <= smul(sc_in[LANE_YAW].c, sc_in[LANE_ROLL].c);
         sysr1_ff  <= smul(sc_in[LANE_YAW].s, sc_in[LANE_ROLL].s);
         cysr1_ff  <= smul(sc_in[LANE_YAW].c, sc_in[LANE_ROLL].s);
         sycr1_ff  <= smul(sc_in[LANE_YAW].s, sc_in[LANE_ROLL].c);
         sr1_ff    <= sc_in[LANE_ROLL].s;
         cr1_ff    <= sc_in[LANE_ROLL].c;
         sp1_ff    <= sc_in[LANE_PITCH].s;
      end
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (en[1]) begin
         cysp_ff  <= round30(cysp_p_ff);
         sysp_ff  <= round30(sysp_p_ff);
         sr2_ff   <= sr1_ff;
         cr2_ff   <= cr1_ff;
         sp2_ff   <= sp1_ff;
         cycp2_ff <= cycp_ff;
         sycp2_ff <= sycp_ff;
         cpsr2_ff <= cpsr_ff;
         cpcr2_ff <= cpcr_ff;
         cycr2_ff <= cycr1_ff;
         sysr2_ff <= sysr1_ff;
         cysr2_ff <= cysr1_ff;
         sycr2_ff <= sycr1_ff;
      end
   end

   // stage 3
   always_ff @(posedge clock) begin
      if (en[2]) begin
         qa_ff    <= smul(cysp_ff, sr2_ff);
         qb_ff    <= smul(cysp_ff, cr2_ff);
         qc_ff    <= smul(sysp_ff, sr2_ff);
         qd_ff    <= smul(sysp_ff, cr2_ff);
         sp3_ff   <= sp2_ff;
         cycp3_ff <= cycp2_ff;
         sycp3_ff <= sycp2_ff;
         cpsr3_ff <= cpsr2_ff;
         cpcr3_ff <= cpcr2_ff;
         cycr3_ff <= cycr2_ff;
         sysr3_ff <= sysr2_ff;
         cysr3_ff <= cysr2_ff;
         sycr3_ff <= sycr2_ff;
      end
   end

   // stage 4: entry sums in Q60
   always_ff @(posedge clock) begin
      if (en[3]) begin
         ent_ff[0] <= cycp3_ff;
         ent_ff[1] <= qa_ff - sycr3_ff;
         ent_ff[2] <= qb_ff + sysr3_ff;
         ent_ff[3] <= sycp3_ff;
         ent_ff[4] <= qc_ff + cycr3_ff;
         ent_ff[5] <= qd_ff - cysr3_ff;
         ent_ff[6] <= -(PRW'(sp3_ff) <<< 30);
         ent_ff[7] <= cpsr3_ff;
         ent_ff[8] <= cpcr3_ff;
      end
   end

   // stage 5: round half up and clamp to +-1
   always_comb begin
      for (int e = 0; e < 9; e++) begin
         rnd[e] = (ent_ff[e] + RND) >>> (60 - FRAC);
         if (rnd[e] > LIM) rnd[e] = LIM;
         if (rnd[e] < -LIM) rnd[e] = -LIM;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int e = 0; e < 9; e++) begin
            rot_ff[e] <= rnd[e][COEF_WIDTH-1:0];
         end
      end
   end

   assign rot   = rot_ff;
   assign trans = pos_ff[NSTG-1];

`ifndef SYNTHESIS
   a_rot00_range: assert property (@(posedge clock) disable iff (reset)
      out_vld |-> (PRW'(rot_ff[0]) <= LIM) && (PRW'(rot_ff[0]) >= -LIM))
      else $error("rot_00 outside unit range");
   a_rot11_range: assert property (@(posedge clock) disable iff (reset)
      out_vld |-> (PRW'(rot_ff[4]) <= LIM) && (PRW'(rot_ff[4]) >= -LIM))
      else $error("rot_11 outside unit range");
   a_rot22_range: assert property (@(posedge clock) disable iff (reset)
      out_vld |-> (PRW'(rot_ff[8]) <= LIM) && (PRW'(rot_ff[8]) >= -LIM))
      else $error("rot_22 outside unit range");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTG-1] && !out_rdy |=> vld_ff[NSTG-1] && $stable(rot_ff[0]))
      else $error("stalled result dropped");
`endif

endmodule

[src/rpy_pose_to_homogeneous_matrix_unit.sv]
// top level: roll-pitch-yaw pose to homogeneous transform
//
//  channel   dir  handshake           payload
//  req_chan  in   valid/ready         pos_x/y/z, roll/pitch/yaw_angle
//  rsp_chan  out  valid/ready         rot_00..rot_22, trans_x/y/z
//
// one pose per cycle sustained while rsp_chan is ready; 32 cordic stages, 5 matrix stages
// the cordic chain of 30 add-shift stages sets the latency, the 33x33 multiplies the clock
// synchronous active-high reset clears only the stage valid bits
// each stage loads when empty or draining, so a stall holds every item in place
module rpy_pose_to_homogeneous_matrix_unit
   import rpy_pkg::*;
#(
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
   parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
   parameter int POS_WIDTH   = POS_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rpy_req_if.sink   req_chan,
   rpy_rsp_if.source rsp_chan
);

   logic                          sc_vld;
   logic                          sc_rdy;
   sc_type                        sc     [LANES];
   logic signed [POS_WIDTH-1:0]   sc_pos [LANES];
   logic signed [ANGLE_WIDTH-1:0] ang    [LANES];
   logic signed [POS_WIDTH-1:0]   pos    [LANES];
   logic signed [COEF_WIDTH-1:0]  rot    [9];
   logic signed [POS_WIDTH-1:0]   trans  [LANES];

   // request payload into lanes
   assign ang[LANE_ROLL]  = req_chan.roll_angle;
   assign ang[LANE_PITCH] = req_chan.pitch_angle;
   assign ang[LANE_YAW]   = req_chan.yaw_angle;
   assign pos[0]          = req_chan.pos_x;
   assign pos[1]          = req_chan.pos_y;
   assign pos[2]          = req_chan.pos_z;

   rpy_sincos #(
      .ANGLE_WIDTH (ANGLE_WIDTH),
      .POS_WIDTH   (POS_WIDTH)
   ) u_sincos (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (req_chan.valid),
      .in_rdy  (req_chan.ready),
      .angle   (ang),
      .pos_in  (pos),
      .out_vld (sc_vld),
      .out_rdy (sc_rdy),
      .sc_out  (sc),
      .pos_out (sc_pos)
   );

   rpy_matrix #(
      .COEF_WIDTH (COEF_WIDTH),
      .POS_WIDTH  (POS_WIDTH)
   ) u_matrix (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (sc_vld),
      .in_rdy  (sc_rdy),
      .sc_in   (sc),
      .pos_in  (sc_pos),
      .out_vld (rsp_chan.valid),
      .out_rdy (rsp_chan.ready),
      .rot     (rot),
      .trans   (trans)
   );

   // response payload
   assign rsp_chan.rot_00  = rot[0];
   assign rsp_chan.rot_01  = rot[1];
   assign rsp_chan.rot_02  = rot[2];
   assign rsp_chan.rot_10  = rot[3];
   assign rsp_chan.rot_11  = rot[4];
   assign rsp_chan.rot_12  = rot[5];
   assign rsp_chan.rot_20  = rot[6];
   assign rsp_chan.rot_21  = rot[7];
   assign rsp_chan.rot_22  = rot[8];
   assign rsp_chan.trans_x = trans[0];
   assign rsp_chan.trans_y = trans[1];
   assign rsp_chan.trans_z = trans[2];

endmodule
